### rtl/on_off_delay_timer_bank_assert.svh
// Assertion macros for the on/off delay timer bank checker.
// Used only by the checker file; needs no package.
`ifndef ON_OFF_DELAY_TIMER_BANK_ASSERT_SVH
`define ON_OFF_DELAY_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ODTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ODTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/odtb_pkg.sv
// Shared constants, codes and the controller command type of the timer bank.
// No dependencies.
package odtb_pkg;

    // Number of on-delay timers, and as many off-delay timers (1 to 32).
    localparam int TIMERS  = 16;
    localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int TIDX_W  = 5;
    localparam int COUNT_W = 20;
    localparam int PRESET_W = 16;

    // Division by ten through a reciprocal: exact for counts below 2**22.
    localparam int RECIP_SHIFT = 23;
    localparam logic [COUNT_W-1:0] RECIP = COUNT_W'(((1 << RECIP_SHIFT) + 9) / 10);
    localparam int PROD_W = 2 * COUNT_W;

    // Item kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_ON   = 2'd1;
    localparam logic [1:0] KIND_OFF  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_IDLE = 2'd0;
    localparam logic [1:0] STAT_RUN  = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;     // capture the input word
        logic             tick;     // count down one entry pair
        logic [IDX_W-1:0] tick_idx; // entry visited by the tick sweep
        logic             eval;     // update the addressed timer
        logic             emit;     // drive the result word
    } t_cmd;

endpackage

### rtl/odtb_ctrl.sv
// Controller of the timer bank: sequences tick sweeps and evaluation calls.
// Depends on odtb_pkg.
module odtb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_kind,
    output logic                o_busy,
    output odtb_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_EVAL,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [odtb_pkg::IDX_W-1:0] r_idx;

    // State register and the sweep index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_start) begin
                        case (i_kind)
                            odtb_pkg::KIND_TICK: r_state <= S_TICK;
                            odtb_pkg::KIND_ON:   r_state <= S_EVAL;
                            odtb_pkg::KIND_OFF:  r_state <= S_EVAL;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_TICK: begin
                    if (r_idx == odtb_pkg::IDX_W'(odtb_pkg::TIMERS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EVAL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.tick     = (r_state == S_TICK);
        o_cmd.tick_idx = r_idx;
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.emit     = (r_state == S_EMIT);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/odtb_datapath.sv
// Datapath of the timer bank: per-timer state, count-down, evaluation and result.
// Depends on odtb_pkg.
module odtb_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  odtb_pkg::t_cmd                        i_cmd,
    input  logic [1:0]                            i_kind,
    input  logic [odtb_pkg::TIDX_W-1:0]           i_timer_index,
    input  logic                                  i_in_level,
    input  logic [odtb_pkg::PRESET_W-1:0]         i_preset,
    input  logic                                  i_reset_request,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic                                  o_timer_output,
    output logic [odtb_pkg::PRESET_W-1:0]         o_remaining
);

    localparam int N  = odtb_pkg::TIMERS;
    localparam int CW = odtb_pkg::COUNT_W;

    // Per-timer state of both banks.
    logic          r_on_run  [N];
    logic          r_on_en   [N];
    logic [CW-1:0] r_on_cnt  [N];
    logic          r_on_last [N];
    logic          r_off_run [N];
    logic          r_off_en  [N];
    logic [CW-1:0] r_off_cnt [N];
    logic          r_off_last[N];

    // Captured input word.
    logic [1:0]                     r_kind;
    logic [odtb_pkg::TIDX_W-1:0]    r_tidx;
    logic                           r_level;
    logic [odtb_pkg::PRESET_W-1:0]  r_preset;
    logic                           r_rst;

    // Evaluation results awaiting the output stage.
    logic [1:0]                     r_res_stat;
    logic                           r_res_tout;
    logic [odtb_pkg::PROD_W-1:0]    r_prod;

    // Output word.
    logic                           r_valid;
    logic [1:0]                     r_o_status;
    logic                           r_o_tout;
    logic [odtb_pkg::PRESET_W-1:0]  r_o_remaining;

    logic [odtb_pkg::IDX_W-1:0] w_eidx;
    logic [odtb_pkg::IDX_W-1:0] w_t;
    logic          w_bad;
    logic          w_is_on;
    logic          w_sel_run;
    logic          w_sel_en;
    logic [CW-1:0] w_sel_cnt;
    logic          w_sel_last;
    logic [CW-1:0] w_p10;
    logic          w_rst_path;
    logic          w_arm;
    logic          n_run;
    logic          n_en;
    logic [CW-1:0] n_cnt;
    logic          n_last;
    logic [1:0]    n_stat;
    logic          n_tout;

    assign w_eidx = r_tidx[odtb_pkg::IDX_W-1:0];
    assign w_t    = i_cmd.tick_idx;
    assign w_bad  = ({1'b0, r_tidx} >= (odtb_pkg::TIDX_W + 1)'(N));
    assign w_is_on = (r_kind == odtb_pkg::KIND_ON);

    // Preset times ten as two shifted copies.
    assign w_p10 = CW'({r_preset, 3'b000}) + CW'({r_preset, 1'b0});

    // Select the addressed timer of the addressed bank.
    always_comb begin
        if (w_is_on) begin
            w_sel_run  = r_on_run[w_eidx];
            w_sel_en   = r_on_en[w_eidx];
            w_sel_cnt  = r_on_cnt[w_eidx];
            w_sel_last = r_on_last[w_eidx];
        end else begin
            w_sel_run  = r_off_run[w_eidx];
            w_sel_en   = r_off_en[w_eidx];
            w_sel_cnt  = r_off_cnt[w_eidx];
            w_sel_last = r_off_last[w_eidx];
        end
    end

    // Evaluation: reset path, arming edge, then status of the new state.
    // The active level is high for on-delay and low for off-delay.
    always_comb begin
        w_rst_path = r_rst || (r_level != w_is_on);
        w_arm      = !w_rst_path && (w_sel_last != w_is_on);
        n_run  = w_sel_run;
        n_en   = w_sel_en;
        n_cnt  = w_sel_cnt;
        n_last = w_sel_last;
        if (w_rst_path) begin
            n_run  = 1'b0;
            n_en   = 1'b0;
            n_cnt  = w_p10;
            n_last = r_level;
        end else if (w_arm) begin
            n_run  = 1'b1;
            n_en   = 1'b1;
            n_cnt  = w_p10;
            n_last = w_is_on;
        end
        if (w_bad) begin
            n_stat = odtb_pkg::STAT_BAD;
            n_tout = 1'b0;
        end else if (!w_rst_path && n_run && (n_cnt == '0)) begin
            n_stat = odtb_pkg::STAT_DONE;
            n_tout = w_is_on;
        end else if (!w_rst_path && n_run) begin
            n_stat = odtb_pkg::STAT_RUN;
            n_tout = !w_is_on;
        end else begin
            n_stat = odtb_pkg::STAT_IDLE;
            n_tout = !w_is_on;
        end
    end

    // Timer state: reset, tick count-down of one entry pair, evaluation write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_on_run[i]   <= 1'b0;
                r_on_en[i]    <= 1'b0;
                r_on_cnt[i]   <= '0;
                r_on_last[i]  <= 1'b0;
                r_off_run[i]  <= 1'b0;
                r_off_en[i]   <= 1'b0;
                r_off_cnt[i]  <= '0;
                r_off_last[i] <= 1'b1;
            end
        end else if (i_cmd.tick) begin
            if (r_on_en[w_t] && (r_on_cnt[w_t] != '0)) begin
                r_on_cnt[w_t] <= r_on_cnt[w_t] - CW'(1);
                if (r_on_cnt[w_t] == CW'(1)) begin
                    r_on_en[w_t] <= 1'b0;
                end
            end
            if (r_off_en[w_t] && (r_off_cnt[w_t] != '0)) begin
                r_off_cnt[w_t] <= r_off_cnt[w_t] - CW'(1);
                if (r_off_cnt[w_t] == CW'(1)) begin
                    r_off_en[w_t] <= 1'b0;
                end
            end
        end else if (i_cmd.eval && !w_bad) begin
            if (w_is_on) begin
                r_on_run[w_eidx]  <= n_run;
                r_on_en[w_eidx]   <= n_en;
                r_on_cnt[w_eidx]  <= n_cnt;
                r_on_last[w_eidx] <= n_last;
            end else begin
                r_off_run[w_eidx]  <= n_run;
                r_off_en[w_eidx]   <= n_en;
                r_off_cnt[w_eidx]  <= n_cnt;
                r_off_last[w_eidx] <= n_last;
            end
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_tidx   <= i_timer_index;
            r_level  <= i_in_level;
            r_preset <= i_preset;
            r_rst    <= i_reset_request;
        end
    end

    // Status and the reciprocal product for the count divided by ten.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_res_stat <= n_stat;
            r_res_tout <= n_tout;
            r_prod     <= odtb_pkg::PROD_W'(n_cnt) * odtb_pkg::PROD_W'(odtb_pkg::RECIP);
        end
    end

    // Result word: held for one cycle under the strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= r_res_stat;
            r_o_tout   <= r_res_tout;
            case (r_res_stat)
                odtb_pkg::STAT_RUN:
                    r_o_remaining <= r_prod[odtb_pkg::RECIP_SHIFT +: odtb_pkg::PRESET_W];
                odtb_pkg::STAT_IDLE:
                    r_o_remaining <= r_preset;
                default:
                    r_o_remaining <= '0;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_o_status;
    assign o_timer_output = r_o_tout;
    assign o_remaining    = r_o_remaining;

endmodule

### rtl/on_off_delay_timer_bank.sv
// Top level of the on/off delay timer bank: controller plus datapath.
// Depends on odtb_pkg, odtb_ctrl and odtb_datapath.
//
// A word is taken when start is high and busy is low. A tick word keeps busy
// high through the sweep over all TIMERS entries (16 here): the sweep visits one
// on-delay and one off-delay entry per cycle with a read-modify-write. An
// evaluation word keeps busy high through the state update with the
// divide-by-ten product, then the output register, and its result appears under
// o_valid in the cycle in which busy falls. Kind three is taken, changes nothing
// and gives no result. Each result is shown for exactly one cycle and must be
// taken then; the receiver cannot stall the block.
module on_off_delay_timer_bank (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_kind,
    input  logic [odtb_pkg::TIDX_W-1:0]           i_timer_index,
    input  logic                                  i_in_level,
    input  logic [odtb_pkg::PRESET_W-1:0]         i_preset,
    input  logic                                  i_reset_request,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic                                  o_timer_output,
    output logic [odtb_pkg::PRESET_W-1:0]         o_remaining
);

    odtb_pkg::t_cmd w_cmd;

    // Sequencer.
    odtb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Timer state and result path.
    odtb_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_kind          (i_kind),
        .i_timer_index   (i_timer_index),
        .i_in_level      (i_in_level),
        .i_preset        (i_preset),
        .i_reset_request (i_reset_request),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_timer_output  (o_timer_output),
        .o_remaining     (o_remaining)
    );

endmodule

### rtl/odtb_checker.sv
// Port-level checker for the timer bank, bound to the top level.
// Depends on odtb_pkg and on_off_delay_timer_bank_assert.svh.
`include "on_off_delay_timer_bank_assert.svh"

module odtb_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [1:0]                            i_kind,
    input  logic                                  o_valid,
    input  logic [1:0]                            o_status,
    input  logic                                  o_timer_output,
    input  logic [odtb_pkg::PRESET_W-1:0]         o_remaining
);

    logic w_take_tick;
    logic w_zero_res;
    logic w_bad_res;

    // Conditions seen on the ports.
    assign w_take_tick = start && !busy && (i_kind == odtb_pkg::KIND_TICK);
    assign w_bad_res   = o_valid && (o_status == odtb_pkg::STAT_BAD);
    assign w_zero_res  = o_valid && ((o_status == odtb_pkg::STAT_BAD) ||
                                     (o_status == odtb_pkg::STAT_DONE));

    // A result word never lasts more than one cycle.
    `ODTB_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")

    // A result only appears once the block has gone idle.
    `ODTB_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")

    // A tick word gives no result in the next cycle and keeps the block busy.
    `ODTB_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, w_take_tick, busy && !o_valid, "tick not taken")

    // A bad index or done result carries a zero remaining time.
    `ODTB_ASSERT_NOW(a_zero_rem, i_clk, i_rst_n, w_zero_res, o_remaining == '0, "nonzero remaining")

    // A bad index result keeps the timer output low.
    `ODTB_ASSERT_NOW(a_bad_tout, i_clk, i_rst_n, w_bad_res, !o_timer_output, "bad index output")

endmodule

bind on_off_delay_timer_bank odtb_checker u_odtb_checker (.*);
